>>> design/tes_pkg.sv
// Shared types and constants of the timed event scheduler.
// No dependencies.
package tes_pkg;
	localparam int SLOTS_DEF = 32;
	localparam int TW = 48;
	localparam int INFO_W = 43;
	localparam int NGATES = 3;

	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_SCHED = 2'd1;
	localparam logic [1:0] FN_CANCEL = 2'd2;
	localparam logic [1:0] FN_GATE  = 2'd3;

	localparam logic [1:0] K_EVENT = 2'd0;
	localparam logic [1:0] K_DONE  = 2'd3;

	localparam logic [1:0] R_SCALE = 2'd0;
	localparam logic [1:0] R_TICK  = 2'd1;
	localparam logic [1:0] R_GATE  = 2'd2;
	localparam logic [1:0] R_CROSS = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  crossing;
		logic [3:0]  event_code;
		logic        track;
		logic        is_timer;
		logic [2:0]  tmr_sel;
		logic [31:0] tmr_stamp;
		logic [11:0] wait_s;
		logic [5:0]  gate_motion;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  target;
		logic [3:0]  code;
		logic [2:0]  track_or_timer;
		logic [31:0] generation;
		logic        accepted;
		logic [5:0]  processed;
		logic        last;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // latch input item
		logic advance;   // add tick advance to now
		logic gate_arm;  // arm gate timer
		logic gate_chk;  // evaluate gate at gidx
		logic slot_rd;   // read slot at sidx
		logic slot_chk;  // act on the slot read by slot_rd
		logic emit;      // load output register
		logic done;      // load completion item
	} cmd_t;

	typedef struct packed {
		logic emit_ok;   // current check produces a result
		logic out_busy;  // output register holds a beat
	} sts_t;
endpackage

>>> design/tes_if.sv
// Valid/ready channel interfaces for the scheduler.
// Depends on tes_pkg.
interface tes_in_if;
	import tes_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tes_out_if;
	import tes_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tes_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> design/tes_datapath.sv
// Datapath: time base, slot memories, gate timers, output register.
// Depends on tes_pkg.
module tes_datapath #(
	parameter int SLOTS = tes_pkg::SLOTS_DEF,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tes_pkg::cmd_t       cmd,
	input  tes_pkg::in_item_t   in_item,
	input  logic [IW-1:0]       sidx,
	input  logic [1:0]          gidx,
	input  logic                out_take,
	input  logic [6:0]          speed,
	input  logic [9:0]          tick_ms,
	input  logic [5:0]          gate_secs,
	output tes_pkg::sts_t       sts,
	output tes_pkg::out_item_t  out_item,
	output logic                out_valid
);
	import tes_pkg::*;

	in_item_t              it_q;
	logic [TW-1:0]         now_q;
	logic [SLOTS-1:0]      valid_q;
	logic [TW-1:0]         dl_mem [SLOTS];
	logic [INFO_W-1:0]     info_mem [SLOTS];
	logic [TW-1:0]         dl_q;
	logic [INFO_W-1:0]     info_q;
	logic [IW-1:0]         rd_idx_q;
	logic [NGATES-1:0]     gpend_q;
	logic [TW-1:0]         gdl_q [NGATES];
	logic [5:0]            proc_q;
	logic                  acc_q;
	out_item_t             out_q;
	logic                  ov_q;
	logic [IW-1:0]         free_idx;
	logic                  free_any;
	logic [16:0]           adv;
	logic [21:0]           dms;
	logic [15:0]           gms;
	logic                  slot_due, slot_tgt, cancel_hit, gate_due;
	logic [1:0]            gm;

	assign adv = 17'(tick_ms * speed);
	assign dms = 22'(in_item.wait_s * 10'd1000);
	assign gms = 16'(gate_secs * 10'd1000);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign gm = it_q.gate_motion[2*gidx +: 2];
	assign gate_due = gpend_q[gidx] && (now_q >= gdl_q[gidx]);
	assign slot_due = valid_q[rd_idx_q] && (now_q >= dl_q);
	assign slot_tgt = info_q[1:0] != 2'd0;
	assign cancel_hit = valid_q[rd_idx_q] && info_q[1:0] == it_q.crossing &&
		info_q[7] && info_q[10:8] == it_q.tmr_sel;

	always_comb begin
		sts.out_busy = ov_q;
		if (cmd.gate_chk)
			sts.emit_ok = gate_due && (gm == 2'd1 || gm == 2'd2);
		else
			sts.emit_ok = it_q.func == FN_TICK && slot_due && slot_tgt;
	end

	// memories: write on schedule, registered read
	always_ff @(posedge clk) begin
		if (cmd.load && in_item.func == FN_SCHED && free_any) begin
			dl_mem[free_idx] <= TW'(now_q + TW'(dms));
			info_mem[free_idx] <= {in_item.tmr_stamp, in_item.tmr_sel,
				in_item.is_timer, in_item.track, in_item.event_code, in_item.crossing};
		end
		if (cmd.slot_rd) begin
			dl_q <= dl_mem[sidx];
			info_q <= info_mem[sidx];
			rd_idx_q <= sidx;
		end
		if (cmd.load)
			it_q <= in_item;
		if (cmd.gate_arm && it_q.crossing != 2'd0)
			gdl_q[it_q.crossing - 2'd1] <= now_q + TW'(gms);
	end

	// control state of the tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			valid_q <= '0;
			gpend_q <= '0;
			proc_q <= '0;
			acc_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				proc_q <= '0;
				acc_q <= in_item.func == FN_SCHED && free_any;
				if (in_item.func == FN_SCHED && free_any)
					valid_q[free_idx] <= 1'b1;
			end
			if (cmd.advance)
				now_q <= now_q + TW'(adv);
			// a gate command without a target arms nothing
			if (cmd.gate_arm && it_q.crossing != 2'd0)
				gpend_q[it_q.crossing - 2'd1] <= 1'b1;
			if (cmd.gate_chk && gate_due) begin
				gpend_q[gidx] <= 1'b0;
				if (gm == 2'd1 || gm == 2'd2)
					proc_q <= proc_q + 6'd1;
			end
			if (cmd.slot_chk) begin
				if (it_q.func == FN_TICK && slot_due) begin
					valid_q[rd_idx_q] <= 1'b0;
					proc_q <= proc_q + 6'd1;
				end
				if (it_q.func == FN_CANCEL && cancel_hit)
					valid_q[rd_idx_q] <= 1'b0;
			end
			if (out_take)
				ov_q <= 1'b0;
			if (cmd.emit || cmd.done)
				ov_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			out_q <= {K_DONE, 2'd0, 4'd0, 3'd0, 32'd0, acc_q, proc_q, 1'b1};
		end else if (cmd.emit && cmd.gate_chk) begin
			out_q <= {gm, gidx + 2'd1, 4'd0, 3'd0, 32'd0, 1'b0, 6'd0, 1'b0};
		end else if (cmd.emit) begin
			out_q <= {K_EVENT, info_q[1:0], info_q[5:2],
				info_q[7] ? info_q[10:8] : {2'b00, info_q[6]},
				info_q[7] ? info_q[42:11] : 32'd0, 1'b0, 6'd0, 1'b0};
		end
	end

	assign out_item = out_q;
	assign out_valid = ov_q;
endmodule

>>> design/tes_ctrl.sv
// Controller: sequences load, gate checks, slot sweep and completion.
// Depends on tes_pkg.
module tes_ctrl #(
	parameter int SLOTS = tes_pkg::SLOTS_DEF,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_func,
	input  logic [1:0]     crossing_count,
	input  tes_pkg::sts_t  sts,
	output logic           in_ready,
	output tes_pkg::cmd_t  cmd,
	output logic [IW-1:0]  sidx,
	output logic [1:0]     gidx
);
	import tes_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_GATE = 7'b0000100,
		ST_RD   = 7'b0001000,
		ST_CHK  = 7'b0010000,
		ST_DONE = 7'b0100000,
		ST_WAIT = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	logic [1:0]    func_q;
	logic [IW:0]   sidx_q;
	logic [1:0]    gidx_q;
	logic          last_slot;

	assign sidx = sidx_q[IW-1:0];
	assign gidx = gidx_q;
	assign in_ready = state_q == ST_IDLE;
	assign last_slot = sidx_q == (IW+1)'(SLOTS - 1);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				priority if (func_q == FN_TICK) begin
					cmd.advance = 1'b1;
					state_d = ST_GATE;
				end else if (func_q == FN_CANCEL) begin
					state_d = ST_RD;
				end else begin
					cmd.gate_arm = func_q == FN_GATE;
					state_d = ST_DONE;
				end
			end
			ST_GATE: begin
				if (gidx_q >= crossing_count || gidx_q == 2'd3) begin
					state_d = ST_RD;
				end else if (!sts.out_busy) begin
					cmd.gate_chk = 1'b1;
					cmd.emit = sts.emit_ok;
				end
			end
			ST_RD: begin
				cmd.slot_rd = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (!sts.out_busy) begin
					cmd.slot_chk = 1'b1;
					cmd.emit = sts.emit_ok;
					state_d = last_slot ? ST_DONE : ST_RD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.done = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!sts.out_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q <= FN_TICK;
			sidx_q <= '0;
			gidx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				func_q <= in_func;
				sidx_q <= '0;
				gidx_q <= '0;
			end
			if (cmd.gate_chk)
				gidx_q <= gidx_q + 2'd1;
			if (cmd.slot_chk)
				sidx_q <= sidx_q + 1'b1;
		end
	end
endmodule

>>> design/timed_event_scheduler_top.sv
// Top level of the timed event scheduler: config registers, controller, datapath.
// Depends on tes_pkg, tes_if, tes_ctrl and tes_datapath.
//
// One item at a time. A schedule, a gate command or a cancel ends in a completion beat;
// a cancel first sweeps the slot memory. A tick checks up to three gate timers, one a
// cycle while the output register is free, then sweeps all SLOTS entries through the
// registered memory read port. A result beat is held in one output register and the
// sweep waits while it is full. No clearing pass after reset.
module timed_event_scheduler_top #(
	parameter int SLOTS = tes_pkg::SLOTS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	tes_in_if.sink  in_ch,
	tes_out_if.source out_ch,
	tes_cfg_if.sink cfg
);
	import tes_pkg::*;
	localparam int IW = $clog2(SLOTS);

	logic [6:0] scale_q;
	logic [9:0] tick_q;
	logic [5:0] gsec_q;
	logic [1:0] cross_q;
	cmd_t       cmd;
	sts_t       sts;
	logic [IW-1:0] sidx;
	logic [1:0] gidx;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 7'd1;
			tick_q <= 10'd100;
			gsec_q <= 6'd5;
			cross_q <= 2'd3;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				R_SCALE: scale_q <= cfg.wdata[6:0];
				R_TICK:  tick_q <= cfg.wdata[9:0];
				R_GATE:  gsec_q <= cfg.wdata[5:0];
				R_CROSS: cross_q <= cfg.wdata[1:0];
				default: ;
			endcase
		end
	end

	tes_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_func(in_ch.data.func),
		.crossing_count(cross_q), .sts,
		.in_ready(in_ch.ready), .cmd, .sidx, .gidx
	);

	tes_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk, .arst_n, .cmd, .in_item(in_ch.data), .sidx, .gidx,
		.out_take(out_ch.valid && out_ch.ready),
		.speed(scale_q), .tick_ms(tick_q), .gate_secs(gsec_q),
		.sts, .out_item(out_ch.data), .out_valid(out_ch.valid)
	);
endmodule
